// ----- src/pim_pkg.sv -----
package pim_pkg;

    // Configuration of the lock.
    localparam int NUM_TASKS   = 16;
    localparam int LOWEST_PRIO = 31;

    // Field widths of a request and a response.
    localparam int TASK_ID_W = 4;
    localparam int PRIO_W    = 5;

    // Internal widths derived from the configuration.
    localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PRIO_CMP_W = 8;
    localparam int ID_CMP_W   = 8;

    // Operation codes.
    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [TASK_ID_W-1:0] task_id;
        logic [PRIO_W-1:0]    task_prio;
        logic [PRIO_W-1:0]    task_base_prio;
    } t_req;

    typedef struct packed {
        logic                 granted;
        logic                 blocked;
        logic                 boost_owner;
        logic [TASK_ID_W-1:0] owner_id;
        logic [PRIO_W-1:0]    owner_prio;
        logic                 ignored;
        logic                 restore_prio;
        logic                 woken_valid;
        logic [TASK_ID_W-1:0] woken_id;
        logic                 switch_needed;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan_clr;
        logic scan_step;
        logic commit;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- src/pim_if.sv -----
interface pim_req_if;
    import pim_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pim_rsp_if;
    import pim_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/pim_ctrl.sv -----
module pim_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  pim_pkg::t_dp_sts   i_sts,
    output pim_pkg::t_ctl_cmd  o_cmd
);
    import pim_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands for the datapath.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // No request is taken while reset is held.
                o_req_ready = i_rst_n;
                if (i_req_valid && i_rst_n) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_scan) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last waiter entry is compared in this cycle.
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/pim_dp.sv -----
module pim_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pim_pkg::t_req      i_req_data,
    input  pim_pkg::t_ctl_cmd  i_cmd,
    output pim_pkg::t_dp_sts   o_sts,
    output logic               o_rsp_valid,
    output pim_pkg::t_rsp      o_rsp_data,
    input  logic               i_rsp_ready
);
    import pim_pkg::*;

    // Mutex state.
    logic                  r_free;
    logic [TASK_ID_W-1:0]  r_holder_id;
    logic [PRIO_W-1:0]     r_holder_prio;
    logic [NUM_TASKS-1:0]  r_wait;
    logic                  n_free;
    logic [TASK_ID_W-1:0]  n_holder_id;
    logic [PRIO_W-1:0]     n_holder_prio;
    logic [NUM_TASKS-1:0]  n_wait;

    // Stored waiter priorities.
    logic [PRIO_W-1:0]     r_mem [NUM_TASKS];
    logic                  n_mem_we;

    // Latched request.
    t_req                  r_req;

    // Waiter scan.
    logic [IDX_W-1:0]      r_scan_idx;
    logic [PRIO_W-1:0]     r_rd_data;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_rd_vld;
    logic [PRIO_CMP_W-1:0] r_best_prio;
    logic [IDX_W-1:0]      r_best_idx;
    logic                  r_found;

    // Response register.
    logic                  r_out_valid;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;

    logic                  id_ok;
    logic                  is_owner;
    logic [IDX_W-1:0]      req_idx;
    logic                  better;

    assign req_idx  = IDX_W'(r_req.task_id);
    assign id_ok    = ID_CMP_W'(r_req.task_id) < ID_CMP_W'(NUM_TASKS);
    assign is_owner = !r_free && (r_holder_id == r_req.task_id);

    assign o_sts.need_scan = id_ok && (r_req.operation == OP_UNLOCK) && is_owner;
    assign o_sts.scan_last = r_scan_idx == IDX_W'(NUM_TASKS - 1);
    assign o_sts.out_free  = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_rsp;

    // A read entry beats the best so far only when strictly more urgent,
    // so ties keep the lower id.
    assign better = r_rd_vld && r_wait[r_rd_idx]
                    && (PRIO_CMP_W'(r_rd_data) < r_best_prio);

    // Outcome of the request and the next mutex state.
    always_comb begin
        n_free        = r_free;
        n_holder_id   = r_holder_id;
        n_holder_prio = r_holder_prio;
        n_wait        = r_wait;
        n_mem_we      = 1'b0;
        n_rsp         = '0;
        if (!id_ok) begin
            n_rsp.ignored = 1'b1;
        end else if (r_req.operation == OP_LOCK) begin
            if (r_free) begin
                n_free          = 1'b0;
                n_holder_id     = r_req.task_id;
                n_holder_prio   = r_req.task_prio;
                n_rsp.granted   = 1'b1;
            end else begin
                n_wait[req_idx]     = 1'b1;
                n_mem_we            = 1'b1;
                n_rsp.blocked       = 1'b1;
                n_rsp.switch_needed = 1'b1;
                if (r_holder_prio > r_req.task_prio) begin
                    n_holder_prio     = r_req.task_prio;
                    n_rsp.boost_owner = 1'b1;
                end
            end
        end else if (!is_owner) begin
            n_rsp.ignored = 1'b1;
        end else begin
            n_rsp.restore_prio = r_req.task_prio != r_req.task_base_prio;
            if (r_found) begin
                n_free                = 1'b0;
                n_holder_id           = TASK_ID_W'(r_best_idx);
                n_holder_prio         = r_best_prio[PRIO_W-1:0];
                n_wait[r_best_idx]    = 1'b0;
                n_rsp.woken_valid     = 1'b1;
                n_rsp.woken_id        = TASK_ID_W'(r_best_idx);
            end else begin
                n_free        = 1'b1;
                n_holder_id   = '0;
                n_holder_prio = '0;
            end
            n_rsp.switch_needed = n_rsp.restore_prio || r_found;
        end
        if (!n_free) begin
            n_rsp.owner_id   = n_holder_id;
            n_rsp.owner_prio = n_holder_prio;
        end
    end

    // Control state: mutex, wait set and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free        <= 1'b1;
            r_holder_id   <= '0;
            r_holder_prio <= '0;
            r_wait        <= '0;
            r_out_valid   <= 1'b0;
            r_rd_vld      <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free        <= n_free;
                r_holder_id   <= n_holder_id;
                r_holder_prio <= n_holder_prio;
                r_wait        <= n_wait;
                r_out_valid   <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= i_cmd.scan_step;
        end
    end

    // Request latch, scan registers and response payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_data;
        end
        if (i_cmd.scan_clr) begin
            r_scan_idx  <= '0;
            r_best_prio <= PRIO_CMP_W'(LOWEST_PRIO);
            r_best_idx  <= '0;
            r_found     <= 1'b0;
        end else begin
            if (i_cmd.scan_step && !o_sts.scan_last) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
            if (better) begin
                r_best_prio <= PRIO_CMP_W'(r_rd_data);
                r_best_idx  <= r_rd_idx;
                r_found     <= 1'b1;
            end
        end
        r_rd_idx <= r_scan_idx;
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    // Waiter priority memory: written when a task blocks, read by the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_mem_we) begin
            r_mem[req_idx] <= r_req.task_prio;
        end
        r_rd_data <= r_mem[r_scan_idx];
    end

endmodule

// ----- src/priority_inheritance_mutex.sv -----
// Channel   Direction  Payload  Handshake
// i_req     in         t_req    valid/ready, taken when both high
// o_rsp     out        t_rsp    valid/ready, taken when both high
//
// A lock, or any ignored request, passes through S_DECIDE and S_FINISH after it is
// accepted; its response is registered when S_FINISH commits it.
// An unlock by the owner also passes through S_SCAN, one step per waiter entry, and
// S_DRAIN before S_FINISH registers its response: the waiter scan reads one entry per cycle.
// One request is in progress at a time; a new one is accepted while the
// previous response still waits in the output register, and it stalls in its
// last cycle until that response is taken.
// Reset is synchronous and active low; it frees the mutex and clears all waiters.
module priority_inheritance_mutex (
    input logic          i_clk,
    input logic          i_rst_n,
    pim_req_if.sink      i_req,
    pim_rsp_if.source    o_rsp
);
    import pim_pkg::*;

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    // Sequencer for the request.
    pim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Mutex state, waiter memory, scan and response register.
    pim_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data),
        .i_rsp_ready (o_rsp.ready)
    );

endmodule

// ----- src/pim_checker.sv -----
module pim_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input pim_pkg::t_rsp i_rsp_data
);
    import pim_pkg::*;

    // Only one kind of outcome per response.
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> $onehot0({i_rsp_data.granted, i_rsp_data.blocked,
                                  i_rsp_data.ignored,
                                  i_rsp_data.restore_prio || i_rsp_data.woken_valid}))
        else $error("response carries more than one outcome");

    // A switch is requested exactly when the caller blocks, restores or wakes a waiter.
    a_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.switch_needed ==
                         (i_rsp_data.blocked || i_rsp_data.restore_prio
                          || i_rsp_data.woken_valid)))
        else $error("switch_needed does not match the outcome");

    // A woken waiter becomes the owner.
    a_woken_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_data.woken_valid) |->
            (i_rsp_data.owner_id == i_rsp_data.woken_id))
        else $error("woken task is not reported as owner");

    // A boost only comes with a blocked lock.
    a_boost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_data.boost_owner) |-> i_rsp_data.blocked)
        else $error("owner boosted without a blocked lock");

    // A stalled response holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)))
        else $error("stalled response changed");

endmodule

bind priority_inheritance_mutex pim_checker u_pim_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
